// ----- rtl/mfm_pkg.sv -----
// ----------------------------------------------------------------------------
// mfm_pkg
// Shared types and fixed field widths of the masked frame mean block.
// ----------------------------------------------------------------------------
package mfm_pkg;

  // Fixed widths of the item fields and of the frame size register.
  localparam int unsigned PIXEL_W  = 16;
  localparam int unsigned INDEX_W  = 18;
  localparam int unsigned FSIZE_W  = 19;
  localparam int unsigned MEAN_W   = 24;
  localparam int unsigned REGION_W = 19;
  localparam int unsigned FRAME_W  = 16;

  // Mask memory rows hold 2**COL_W mask bits each.
  localparam int unsigned COL_W    = 6;

  // Frame size after reset.
  localparam logic [FSIZE_W-1:0] FSIZE_RST = 19'd262144;

  // Item kinds selected by the action field.
  typedef enum logic {
    ACT_MASK_WRITE = 1'b0,
    ACT_PIXEL      = 1'b1
  } action_e;

  // Divider sequencer states.
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  // Divider status seen by the control logic.
  typedef struct packed {
    logic ready;
    logic done;
  } div_status_t;

endpackage

// ----- rtl/mfm_mask_mem.sv -----
// ----------------------------------------------------------------------------
// mfm_mask_mem
// Mask bit memory organized in rows of 64 bits, with a bit write port, a
// registered row read and a clearing sweep of one row per cycle after reset.
// ----------------------------------------------------------------------------
module mfm_mask_mem #(
  parameter int unsigned ROWS  = 4096,
  parameter int unsigned ROW_W = 12,
  parameter int unsigned ADDR_W = 18
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic              wr_bit_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic              rd_bit_o,
  output logic              clear_busy_o
);
  import mfm_pkg::*;

  localparam int unsigned COLS = 2 ** COL_W;

  logic [COLS-1:0]  mem_q [ROWS];
  logic [COLS-1:0]  rd_row_q;
  logic [COL_W-1:0] rd_col_q;
  logic [ROW_W-1:0] clr_row_q, clr_row_d;
  logic             clr_busy_q, clr_busy_d;

  // Clearing sweep walks every row once after reset.
  always_comb begin
    clr_row_d  = clr_row_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_row_d = clr_row_q + ROW_W'(1);
      if (clr_row_q == ROW_W'(ROWS - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_row_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_row_q  <= clr_row_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // Storage: whole-row clear during the sweep, single bit writes otherwise.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_row_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i[ADDR_W-1:COL_W]][wr_addr_i[COL_W-1:0]] <= wr_bit_i;
    end
  end

  // Registered row read; the column is picked from the held row.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_row_q <= mem_q[rd_addr_i[ADDR_W-1:COL_W]];
      rd_col_q <= rd_addr_i[COL_W-1:0];
    end
  end

  assign rd_bit_o     = rd_row_q[rd_col_q];
  assign clear_busy_o = clr_busy_q;

endmodule

// ----- rtl/mfm_divider.sv -----
// ----------------------------------------------------------------------------
// mfm_divider
// Restoring divider that forms floor(sum * 2**FRACTION_BITS / count), one
// quotient bit per cycle, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module mfm_divider #(
  parameter int unsigned SUM_W         = 35,
  parameter int unsigned CNT_W         = 19,
  parameter int unsigned FRACTION_BITS = 8,
  parameter int unsigned NUM_W         = 43
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [SUM_W-1:0]            dividend_i,
  input  logic [CNT_W-1:0]            divisor_i,
  input  logic [mfm_pkg::FRAME_W-1:0] frame_i,
  input  logic                        take_i,
  output mfm_pkg::div_status_t        stat_o,
  output logic [NUM_W-1:0]            quotient_o,
  output logic [CNT_W-1:0]            divisor_o,
  output logic [mfm_pkg::FRAME_W-1:0] frame_o
);
  import mfm_pkg::*;

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  div_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [NUM_W-1:0]  num_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  div_q;
  logic [FRAME_W-1:0] frame_q;
  logic [CNT_W:0]    trial;
  logic              qbit;
  logic [CNT_W-1:0]  rem_nxt;

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIV_IDLE: begin
        if (start_i) state_d = DIV_RUN;
      end
      DIV_RUN: begin
        if (step_q == STEP_W'(1)) state_d = DIV_DONE;
      end
      DIV_DONE: begin
        if (take_i) state_d = DIV_IDLE;
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  // Status outputs of the sequencer.
  always_comb begin
    stat_o = '0;
    unique case (state_q)
      DIV_IDLE: stat_o.ready = 1'b1;
      DIV_DONE: stat_o.done  = 1'b1;
      default:  stat_o       = '0;
    endcase
  end

  // Step counter counts the remaining quotient bits.
  always_comb begin
    step_d = step_q;
    if (state_q == DIV_IDLE && start_i) begin
      step_d = STEP_W'(NUM_W);
    end else if (state_q == DIV_RUN) begin
      step_d = step_q - STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial   = {rem_q, num_q[NUM_W-1]};
    qbit    = (trial >= {1'b0, div_q});
    rem_nxt = qbit ? CNT_W'(trial - {1'b0, div_q}) : CNT_W'(trial);
  end

  // Datapath: the dividend register fills with quotient bits from the right.
  always_ff @(posedge clk_i) begin
    if (state_q == DIV_IDLE && start_i) begin
      num_q   <= NUM_W'(dividend_i) << FRACTION_BITS;
      rem_q   <= '0;
      div_q   <= divisor_i;
      frame_q <= frame_i;
    end else if (state_q == DIV_RUN) begin
      num_q <= {num_q[NUM_W-2:0], qbit};
      rem_q <= rem_nxt;
    end
  end

  assign quotient_o = num_q;
  assign divisor_o  = div_q;
  assign frame_o    = frame_q;

endmodule

// ----- rtl/masked_frame_mean.sv -----
// ----------------------------------------------------------------------------
// masked_frame_mean
// Region-of-interest mean per frame over a masked pixel stream.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries two kinds of item. A mask write sets or clears
// one mask bit; a pixel item carries one sample in frame order. Each pixel
// whose mask bit is set adds to a running sum and count. The pixel that ends
// a frame (frame size from the cfg register) yields one result item: the
// mean as unsigned fixed point, truncated, the masked pixel count, an empty
// flag and the frame number.
// Throughput is one item per cycle while in_stall_o is low: a mask write
// uses the memory write port and a pixel its registered read port. The mean
// is formed by a restoring divider; the totals of a frame pass from the
// first stage through the divider into the output register. A frame end waits at
// the input while the previous division is still running or its result is
// still unclaimed.
// After reset the mask memory is cleared one 64-bit row per cycle; input is
// stalled meanwhile, configuration writes are taken at any time. A stalled
// result is held in the output register while new items keep flowing in.
// ----------------------------------------------------------------------------
module masked_frame_mean #(
  parameter int unsigned MAX_PIXELS    = 262144,
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration
  input  logic                         cfg_we_i,
  input  logic [mfm_pkg::FSIZE_W-1:0]  cfg_wdata_i,
  // Input items
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         action_i,
  input  logic [mfm_pkg::INDEX_W-1:0]  mask_index_i,
  input  logic                         mask_bit_i,
  input  logic [mfm_pkg::PIXEL_W-1:0]  pixel_value_i,
  // Result items
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mfm_pkg::MEAN_W-1:0]   mean_value_o,
  output logic [mfm_pkg::REGION_W-1:0] region_pixels_o,
  output logic                         region_empty_o,
  output logic [mfm_pkg::FRAME_W-1:0]  frame_index_o
);
  import mfm_pkg::*;

  localparam int unsigned ROWS   = (MAX_PIXELS + (2 ** COL_W) - 1) / (2 ** COL_W);
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned ADDR_W = ROW_W + COL_W;
  localparam int unsigned CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned SMP_W  = (SAMPLE_BITS < PIXEL_W) ? SAMPLE_BITS : PIXEL_W;
  localparam int unsigned SUM_W  = SMP_W + CNT_W;
  localparam int unsigned NUM_W  = SUM_W + FRACTION_BITS;

  // Configuration register.
  logic [FSIZE_W-1:0] fsize_q;
  logic [31:0]        fsize_w;
  logic [ADDR_W-1:0]  size_m1;

  // Front end and first stage.
  logic              in_accept, pixel_accept, mask_accept, mask_in_range;
  logic              clear_busy, rd_bit;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic              pos_last;
  logic              s1_valid_q, s1_valid_d;
  logic              s1_last_q;
  logic [SMP_W-1:0]  s1_sample_q;
  logic              s1_stuck, s1_fire, hit;

  // Accumulators and frame counter.
  logic [SUM_W-1:0]   sum_q, sum_d, sum_inc;
  logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_inc;
  logic [FRAME_W-1:0] frame_q, frame_d;

  // Divider and output register.
  div_status_t        div_stat;
  logic               div_start, div_take;
  logic [NUM_W-1:0]   div_quot;
  logic [CNT_W-1:0]   div_cnt;
  logic [FRAME_W-1:0] div_frame;
  logic               out_valid_q, out_valid_d;
  logic [MEAN_W-1:0]  mean_q;
  logic [REGION_W-1:0] region_q;
  logic               empty_q;
  logic [FRAME_W-1:0] frame_out_q;

  // Frame size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsize_q <= FSIZE_RST;
    end else if (cfg_we_i) begin
      fsize_q <= cfg_wdata_i;
    end
  end

  // Effective frame size: zero counts as one, large sizes saturate.
  always_comb begin
    fsize_w = 32'(fsize_q);
    if (fsize_w == 32'd0) fsize_w = 32'd1;
    if (fsize_w > 32'(MAX_PIXELS)) fsize_w = 32'(MAX_PIXELS);
    size_m1 = ADDR_W'(fsize_w - 32'd1);
  end

  // Input handshake; a frame end waiting for the divider holds the input.
  assign s1_stuck      = s1_valid_q && s1_last_q && !div_stat.ready;
  assign s1_fire       = s1_valid_q && !s1_stuck;
  assign in_stall_o    = clear_busy || s1_stuck;
  assign in_accept     = in_valid_i && !in_stall_o;
  assign pixel_accept  = in_accept && (action_e'(action_i) == ACT_PIXEL);
  assign mask_accept   = in_accept && (action_e'(action_i) == ACT_MASK_WRITE);
  assign mask_in_range = (32'(mask_index_i) < 32'(MAX_PIXELS));
  assign pos_last      = (pos_q >= size_m1);

  // Pixel position within the frame.
  always_comb begin
    pos_d = pos_q;
    if (pixel_accept) begin
      pos_d = pos_last ? '0 : pos_q + ADDR_W'(1);
    end
  end

  mfm_mask_mem #(
    .ROWS   (ROWS),
    .ROW_W  (ROW_W),
    .ADDR_W (ADDR_W)
  ) u_mask_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (mask_accept && mask_in_range),
    .wr_addr_i    (ADDR_W'(mask_index_i)),
    .wr_bit_i     (mask_bit_i),
    .rd_en_i      (pixel_accept),
    .rd_addr_i    (pos_q),
    .rd_bit_o     (rd_bit),
    .clear_busy_o (clear_busy)
  );

  // First stage holds the sample while its mask bit is read.
  assign s1_valid_d = pixel_accept || s1_stuck;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      s1_valid_q <= s1_valid_d;
      if (pixel_accept) s1_last_q <= pos_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pixel_accept) s1_sample_q <= SMP_W'(pixel_value_i);
  end

  // Accumulate masked pixels; a frame end hands the totals to the divider.
  always_comb begin
    hit       = s1_fire && rd_bit;
    sum_inc   = sum_q + (hit ? SUM_W'(s1_sample_q) : '0);
    cnt_inc   = cnt_q + (hit ? CNT_W'(1) : '0);
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    frame_d   = frame_q;
    div_start = 1'b0;
    if (s1_fire) begin
      if (s1_last_q) begin
        div_start = 1'b1;
        sum_d     = '0;
        cnt_d     = '0;
        frame_d   = frame_q + FRAME_W'(1);
      end else begin
        sum_d = sum_inc;
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      cnt_q   <= '0;
      frame_q <= '0;
    end else begin
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      frame_q <= frame_d;
    end
  end

  mfm_divider #(
    .SUM_W         (SUM_W),
    .CNT_W         (CNT_W),
    .FRACTION_BITS (FRACTION_BITS),
    .NUM_W         (NUM_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_inc),
    .divisor_i  (cnt_inc),
    .frame_i    (frame_q),
    .take_i     (div_take),
    .stat_o     (div_stat),
    .quotient_o (div_quot),
    .divisor_o  (div_cnt),
    .frame_o    (div_frame)
  );

  // Output register takes a finished result whenever it is free or draining.
  assign div_take = div_stat.done && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (div_take) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_take) begin
      mean_q      <= (div_cnt == '0) ? '0 : MEAN_W'(div_quot);
      region_q    <= REGION_W'(div_cnt);
      empty_q     <= (div_cnt == '0);
      frame_out_q <= div_frame;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mean_value_o    = mean_q;
  assign region_pixels_o = region_q;
  assign region_empty_o  = empty_q;
  assign frame_index_o   = frame_out_q;

  // The divider is only started when it is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> div_stat.ready)
    else $error("divider started while busy");

  // An empty region reports a zero mean and a zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && region_empty_o) |-> (mean_value_o == '0 && region_pixels_o == '0))
    else $error("empty region with nonzero mean or count");

  // The pixel position never passes the largest frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= ADDR_W'(MAX_PIXELS - 1))
    else $error("pixel position out of range");

  // No pixel is in flight while the mask memory is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy |-> !s1_valid_q)
    else $error("pixel in flight during mask clear");

endmodule
